// ===== hdl/sc1a_pkg.sv =====
// Shared types, constants and the Set 1 keymap for the scancode-to-ASCII block.
package sc1a_pkg;

  localparam int unsigned DEPTH_DFLT = 256;

  localparam logic [7:0] PFX_E0    = 8'hE0;
  localparam logic [7:0] PFX_E1    = 8'hE1;
  localparam int unsigned BREAK_BIT = 7;

  localparam logic REQ_SCAN = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [6:0] CH_NONE = 7'h00;
  localparam logic [6:0] CH_ESC  = 7'h1B;
  localparam logic [6:0] CH_BS   = 7'h08;
  localparam logic [6:0] CH_TAB  = 7'h09;
  localparam logic [6:0] CH_LF   = 7'h0A;

  // Translation of one scancode word
  typedef struct packed {
    logic       push;
    logic [6:0] ch;
  } sc1a_key_t;

  // Per-word status carried with a result
  typedef struct packed {
    logic char_valid;
    logic data_avail;
    logic dropped;
  } sc1a_stat_t;

  // Output buffer steering, shared with the character RAM read registers
  typedef struct packed {
    logic load_out;
    logic load_skid;
    logic skid_to_out;
  } sc1a_buf_ctl_t;

  // US lowercase keymap for make codes 0x00..0x7F
  function automatic logic [6:0] keymap(input logic [6:0] code);
    logic [6:0] ch;
    case (code)
      7'h01: ch = CH_ESC;
      7'h02: ch = 7'h31;
      7'h03: ch = 7'h32;
      7'h04: ch = 7'h33;
      7'h05: ch = 7'h34;
      7'h06: ch = 7'h35;
      7'h07: ch = 7'h36;
      7'h08: ch = 7'h37;
      7'h09: ch = 7'h38;
      7'h0A: ch = 7'h39;
      7'h0B: ch = 7'h30;
      7'h0C: ch = 7'h2D;
      7'h0D: ch = 7'h3D;
      7'h0E: ch = CH_BS;
      7'h0F: ch = CH_TAB;
      7'h10: ch = 7'h71;
      7'h11: ch = 7'h77;
      7'h12: ch = 7'h65;
      7'h13: ch = 7'h72;
      7'h14: ch = 7'h74;
      7'h15: ch = 7'h79;
      7'h16: ch = 7'h75;
      7'h17: ch = 7'h69;
      7'h18: ch = 7'h6F;
      7'h19: ch = 7'h70;
      7'h1A: ch = 7'h5B;
      7'h1B: ch = 7'h5D;
      7'h1C: ch = CH_LF;
      7'h1E: ch = 7'h61;
      7'h1F: ch = 7'h73;
      7'h20: ch = 7'h64;
      7'h21: ch = 7'h66;
      7'h22: ch = 7'h67;
      7'h23: ch = 7'h68;
      7'h24: ch = 7'h6A;
      7'h25: ch = 7'h6B;
      7'h26: ch = 7'h6C;
      7'h27: ch = 7'h3B;
      7'h28: ch = 7'h27;
      7'h29: ch = 7'h60;
      7'h2B: ch = 7'h5C;
      7'h2C: ch = 7'h7A;
      7'h2D: ch = 7'h78;
      7'h2E: ch = 7'h63;
      7'h2F: ch = 7'h76;
      7'h30: ch = 7'h62;
      7'h31: ch = 7'h6E;
      7'h32: ch = 7'h6D;
      7'h33: ch = 7'h2C;
      7'h34: ch = 7'h2E;
      7'h35: ch = 7'h2F;
      7'h37: ch = 7'h2A;
      7'h39: ch = 7'h20;
      // keypad
      7'h47: ch = 7'h37;
      7'h48: ch = 7'h38;
      7'h49: ch = 7'h39;
      7'h4A: ch = 7'h2D;
      7'h4B: ch = 7'h34;
      7'h4C: ch = 7'h35;
      7'h4D: ch = 7'h36;
      7'h4E: ch = 7'h2B;
      7'h4F: ch = 7'h31;
      7'h50: ch = 7'h32;
      7'h51: ch = 7'h33;
      7'h52: ch = 7'h30;
      7'h53: ch = 7'h2E;
      default: ch = CH_NONE;
    endcase
    return ch;
  endfunction

endpackage

// ===== hdl/sc1a_xlate.sv =====
// Prefix tracking and keymap translation of scancode words.
module sc1a_xlate (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc,
  input  logic                 req_type,
  input  logic [7:0]           scan_byte,
  output sc1a_pkg::sc1a_key_t  key
);

  logic prefix_r;
  logic prefix_nxt;
  logic is_pfx;
  logic [6:0] ch;

  assign is_pfx = (scan_byte == sc1a_pkg::PFX_E0) || (scan_byte == sc1a_pkg::PFX_E1);
  assign ch     = sc1a_pkg::keymap(scan_byte[6:0]);

  always_comb begin
    prefix_nxt = prefix_r;
    key.push   = 1'b0;
    key.ch     = ch;
    if (req_type == sc1a_pkg::REQ_SCAN) begin
      if (is_pfx) begin
        prefix_nxt = 1'b1;
      end else if (prefix_r) begin
        // byte following a prefix is swallowed
        prefix_nxt = 1'b0;
      end else if (!scan_byte[sc1a_pkg::BREAK_BIT]) begin
        key.push = (ch != sc1a_pkg::CH_NONE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= 1'b0;
    end else if (acc) begin
      prefix_r <= prefix_nxt;
    end
  end

endmodule

// ===== hdl/sc1a_ring.sv =====
// Character ring buffer: pointers, storage RAM and registered read data.
module sc1a_ring #(
  parameter int unsigned DEPTH = sc1a_pkg::DEPTH_DFLT
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    acc,
  input  logic                    req_type,
  input  sc1a_pkg::sc1a_key_t     key,
  input  sc1a_pkg::sc1a_buf_ctl_t ctl,
  output sc1a_pkg::sc1a_stat_t    stat,
  output logic [6:0]              out_code
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [6:0] mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_inc, rd_inc;
  logic             not_empty, full, pop, push;
  logic [6:0]       out_code_r, skid_code_r;

  assign wr_inc    = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
  assign rd_inc    = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
  assign not_empty = (wr_ptr_r != rd_ptr_r);
  assign full      = (wr_inc == rd_ptr_r);

  assign pop  = (req_type == sc1a_pkg::REQ_READ) && not_empty;
  assign push = (req_type == sc1a_pkg::REQ_SCAN) && key.push && !full;

  assign wr_ptr_nxt = push ? wr_inc : wr_ptr_r;
  assign rd_ptr_nxt = pop  ? rd_inc : rd_ptr_r;

  assign stat.char_valid = pop;
  assign stat.data_avail = (wr_ptr_nxt != rd_ptr_nxt);
  assign stat.dropped    = (req_type == sc1a_pkg::REQ_SCAN) && key.push && full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else if (acc) begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && push) begin
      mem[wr_ptr_r] <= key.ch;
    end
  end

  // Read data lands in the register of whichever buffer slot takes the word;
  // a pop only reaches slots written at an earlier edge.
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_code_r <= mem[rd_ptr_r];
    end else if (ctl.skid_to_out) begin
      out_code_r <= skid_code_r;
    end
    if (ctl.load_skid) begin
      skid_code_r <= mem[rd_ptr_r];
    end
  end

  assign out_code = out_code_r;

endmodule

// ===== hdl/sc1a_outbuf.sv =====
// Output register with skid slot for the result stream.
module sc1a_outbuf (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  input  logic                    out_tready,
  input  sc1a_pkg::sc1a_stat_t    stat,
  output logic                    acc,
  output logic                    in_ready,
  output logic                    out_valid,
  output sc1a_pkg::sc1a_stat_t    out_stat,
  output sc1a_pkg::sc1a_buf_ctl_t ctl
);

  logic                 out_valid_r, out_valid_nxt;
  logic                 skid_valid_r, skid_valid_nxt;
  sc1a_pkg::sc1a_stat_t out_stat_r, skid_stat_r;
  logic                 drain;

  assign in_ready = !skid_valid_r;
  assign acc      = in_tvalid && in_ready;
  assign drain    = out_valid_r && out_tready;

  always_comb begin
    ctl            = '0;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (drain) begin
        ctl.skid_to_out = 1'b1;
        skid_valid_nxt  = 1'b0;
      end
    end else if (acc) begin
      if (!out_valid_r || drain) begin
        ctl.load_out  = 1'b1;
        out_valid_nxt = 1'b1;
      end else begin
        ctl.load_skid  = 1'b1;
        skid_valid_nxt = 1'b1;
      end
    end else if (drain) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_stat_r <= stat;
    end else if (ctl.skid_to_out) begin
      out_stat_r <= skid_stat_r;
    end
    if (ctl.load_skid) begin
      skid_stat_r <= stat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_stat  = out_stat_r;

endmodule

// ===== hdl/scancode_set1_to_ascii_fifo_top.sv =====
// Top level: Set 1 scancode translator feeding a character ring buffer.
// Each result is registered in the output register, or the skid slot while that stalls.
// Throughput: one word per cycle; a two-slot output buffer (register plus skid)
//   keeps in_tready high unless two results are waiting downstream.
// Reset: pointers, prefix flag and buffer valid flags clear; the character RAM
//   is not cleared, since only written slots are ever read.
module scancode_set1_to_ascii_fifo_top #(
  parameter int unsigned DEPTH = sc1a_pkg::DEPTH_DFLT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] scan_byte
  input  logic [0:0]  in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [6:0] char_code, [7] data_avail, [8] dropped, rest 0
  output logic [0:0]  out_tuser   // [0] char_valid
);

  logic                    acc;
  sc1a_pkg::sc1a_key_t     key;
  sc1a_pkg::sc1a_stat_t    stat;
  sc1a_pkg::sc1a_stat_t    out_stat;
  sc1a_pkg::sc1a_buf_ctl_t ctl;
  logic [6:0]              out_code;

  sc1a_xlate u_xlate (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .req_type  (in_tuser[0]),
    .scan_byte (in_tdata),
    .key       (key)
  );

  sc1a_ring #(
    .DEPTH (DEPTH)
  ) u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .req_type (in_tuser[0]),
    .key      (key),
    .ctl      (ctl),
    .stat     (stat),
    .out_code (out_code)
  );

  sc1a_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .acc        (acc),
    .in_ready   (in_tready),
    .out_valid  (out_tvalid),
    .out_stat   (out_stat),
    .ctl        (ctl)
  );

  // code register holds stale RAM data on non-pop words
  assign out_tdata = {7'b0, out_stat.dropped, out_stat.data_avail,
                      out_code & {7{out_stat.char_valid}}};
  assign out_tuser = out_stat.char_valid;

endmodule

// ===== hdl/sc1a_checker.sv =====
// Port-level checker for the scancode-to-ASCII block, bound to the top level.
module sc1a_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[6:0] == 7'd0)
    else $error("char_code nonzero without char_valid");

  // a drop means the ring was full, so data must remain
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8] |-> out_tdata[7] && !out_tuser[0])
    else $error("dropped reported with empty ring or on a read");

  a_rst_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid && in_tready)
    else $error("output not idle after reset");

  // a read accepted while a result showing data_avail drains always returns data
  a_read_after_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tdata[7] && in_tvalid && in_tready &&
    in_tuser[0] |=> out_tvalid && out_tuser[0])
    else $error("read missed a waiting character");

endmodule

bind scancode_set1_to_ascii_fifo_top sc1a_checker u_sc1a_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
